// File: rtl/core/sorted_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_assert.svh
// Assertion macros used by the checker of the priority queue block.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// checked only while out of reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_READ   = 2'd3
  } spq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOPOS = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_INS,
    S_INS_PUT,
    S_REM,
    S_LK,
    S_RD,
    S_DONE
  } spq_state_t;

  localparam int unsigned CAP_W      = 5;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned IN_TDATA_W = 88;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_PAD_W  = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // result of one request, status in the low bits
  typedef struct packed {
    logic             is_full;
    logic             is_empty;
    logic [CAP_W-1:0] occupancy;
    logic [ID_W-1:0]  handle;
    logic [ID_W-1:0]  display_id;
    logic [KEY_W-1:0] key;
    logic             found;
    spq_status_t      status;
  } spq_res_t;

endpackage

// File: rtl/core/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int unsigned AW = 4,
  parameter int unsigned W  = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: walks the entry store one entry per cycle to shift,
// close gaps, search or read, and keeps the occupancy count.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5,
  parameter int unsigned EW       = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  spq_cmd_t            cmd,
  input  logic [KEY_W-1:0]    new_key,
  input  logic [ID_W-1:0]     new_display_id,
  input  logic [ID_W-1:0]     new_handle,
  input  logic [POS_W-1:0]    position,
  input  logic [ID_W-1:0]     search_id,
  input  logic [CW-1:0]       cap_eff,
  input  logic                res_free,
  output logic                idle,
  output logic                res_valid,
  output spq_res_t            res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [EW-1:0]       mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [EW-1:0]       mem_rdata
);

  localparam int unsigned XW = CW + 1;
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  spq_state_t          state_r, state_nxt;
  spq_cmd_t            cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ID_W-1:0]     nid_r, nid_nxt;
  logic [ID_W-1:0]     nh_r, nh_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ID_W-1:0]     sid_r, sid_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  spq_status_t         status_r, status_nxt;
  logic                found_r, found_nxt;
  logic [KEY_W-1:0]    okey_r, okey_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [ID_W-1:0]     oh_r, oh_nxt;

  logic [KEY_BITS-1:0] rd_key;
  logic [ID_W-1:0]     rd_id;
  logic [ID_W-1:0]     rd_h;
  logic [CW-1:0]       im1, im2, ip1, ip2, pos_c;
  logic                is_full_now, pos_bad, ins_less, more_ins, more_rem, more_lk, id_hit;

  assign rd_key = mem_rdata[EW-1:2*ID_W];
  assign rd_id  = mem_rdata[2*ID_W-1:ID_W];
  assign rd_h   = mem_rdata[ID_W-1:0];

  assign im1   = i_r - ONE;
  assign im2   = i_r - TWO;
  assign ip1   = i_r + ONE;
  assign ip2   = i_r + TWO;
  assign pos_c = CW'(pos_r);

  assign is_full_now = (count_r >= cap_eff);
  // position checked in a wider domain so that it is never truncated first
  assign pos_bad  = ({{(XW > POS_W ? XW - POS_W : 0){1'b0}}, pos_r} >= XW'(count_r));
  assign ins_less = (key_r < rd_key);
  assign more_ins = (im1 != '0);
  assign more_rem = ((XW'(i_r) + XW'(2)) < XW'(count_r));
  assign more_lk  = ((XW'(i_r) + XW'(1)) < XW'(count_r));
  assign id_hit   = (rd_id == sid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    nid_r    <= nid_nxt;
    nh_r     <= nh_nxt;
    pos_r    <= pos_nxt;
    sid_r    <= sid_nxt;
    i_r      <= i_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    okey_r   <= okey_nxt;
    oid_r    <= oid_nxt;
    oh_r     <= oh_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (is_full_now || count_r == '0) state_nxt = S_DONE;
            else state_nxt = S_INS;
          end
          CMD_REMOVE: begin
            if (pos_bad || !((XW'(pos_r) + XW'(1)) < XW'(count_r))) state_nxt = S_DONE;
            else state_nxt = S_REM;
          end
          CMD_LOOKUP: begin
            if (count_r == '0) state_nxt = S_DONE;
            else state_nxt = S_LK;
          end
          CMD_READ: begin
            if (pos_bad) state_nxt = S_DONE;
            else state_nxt = S_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_INS: begin
        if (!ins_less) state_nxt = S_DONE;
        else if (!more_ins) state_nxt = S_INS_PUT;
      end
      S_INS_PUT: state_nxt = S_DONE;
      S_REM: begin
        if (!more_rem) state_nxt = S_DONE;
      end
      S_LK: begin
        if (id_hit || !more_lk) state_nxt = S_DONE;
      end
      S_RD: state_nxt = S_DONE;
      S_DONE: begin
        if (res_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    nid_nxt    = nid_r;
    nh_nxt     = nh_r;
    pos_nxt    = pos_r;
    sid_nxt    = sid_r;
    i_nxt      = i_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    okey_nxt   = okey_r;
    oid_nxt    = oid_r;
    oh_nxt     = oh_r;
    mem_we     = 1'b0;
    mem_waddr  = i_r[AW-1:0];
    mem_wdata  = {key_r, nid_r, nh_r};
    mem_re     = 1'b0;
    mem_raddr  = im1[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          key_nxt    = KEY_BITS'(new_key);
          nid_nxt    = new_display_id;
          nh_nxt     = new_handle;
          pos_nxt    = position;
          sid_nxt    = search_id;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          okey_nxt   = '0;
          oid_nxt    = '0;
          oh_nxt     = '0;
        end
      end
      S_ISSUE: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (is_full_now) begin
              status_nxt = ST_FULL;
            end else if (count_r == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              count_nxt = count_r + ONE;
            end else begin
              i_nxt     = count_r;
              mem_re    = 1'b1;
              mem_raddr = AW'(count_r - ONE);
            end
          end
          CMD_REMOVE: begin
            if (pos_bad) begin
              status_nxt = ST_NOPOS;
            end else if (!((XW'(pos_r) + XW'(1)) < XW'(count_r))) begin
              // last entry: nothing to move
              count_nxt = count_r - ONE;
            end else begin
              i_nxt     = pos_c;
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_c + ONE);
            end
          end
          CMD_LOOKUP: begin
            if (count_r != '0) begin
              i_nxt     = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
          end
          CMD_READ: begin
            if (pos_bad) begin
              status_nxt = ST_NOPOS;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_c);
            end
          end
          default: ;
        endcase
      end
      S_INS: begin
        mem_we = 1'b1;
        if (ins_less) begin
          // shift the larger entry up and fetch the next one down
          mem_wdata = mem_rdata;
          i_nxt     = im1;
          if (more_ins) begin
            mem_re    = 1'b1;
            mem_raddr = im2[AW-1:0];
          end
        end else begin
          count_nxt = count_r + ONE;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + ONE;
      end
      S_REM: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        i_nxt     = ip1;
        if (more_rem) begin
          mem_re    = 1'b1;
          mem_raddr = ip2[AW-1:0];
        end else begin
          count_nxt = count_r - ONE;
        end
      end
      S_LK: begin
        if (id_hit) begin
          found_nxt = 1'b1;
        end else if (more_lk) begin
          i_nxt     = ip1;
          mem_re    = 1'b1;
          mem_raddr = ip1[AW-1:0];
        end
      end
      S_RD: begin
        okey_nxt = KEY_W'(rd_key);
        oid_nxt  = rd_id;
        oh_nxt   = rd_h;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status     = status_r;
    res.found      = found_r;
    res.key        = okey_r;
    res.display_id = oid_r;
    res.handle     = oh_r;
    res.occupancy  = CAP_W'(count_r);
    res.is_empty   = (count_r == '0);
    res.is_full    = is_full_now;
  end

endmodule

// File: rtl/core/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue of (key, display id, handle) entries kept in ascending key
// order in a single-port-write memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake (insert, remove, lookup, read).
//   out_* : one result per request, in request order.
//   cfg_* : capacity register, always ready; write it only while idle.
// Request handling (one request at a time, through the memory walk that
//   handles one entry per cycle through the single read and write port):
//   insert : shifts each larger entry up, then writes the new entry.
//   remove : moves each entry above the position down.
//   lookup : scans entries up to the first match.
//   read   : fetches the entry at the position.
//   The next request is taken the cycle after the result is registered.
// Reset: occupancy goes to zero, capacity to 16, no result pending. Entries
//   are not cleared; no clearing pass is needed.
// Stall: a result waits in the output register; a finished request holds
//   until that register frees, and in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd[1:0], new_key[33:2], new_display_id[49:34], new_handle[65:50],
  // position[69:66], search_id[85:70], zero[87:86]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], found[2], out_key[34:3], out_display_id[50:35],
  // out_handle[66:51], occupancy[71:67], is_empty[72], is_full[73], zero[79:74]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + 2 * ID_W;
  localparam int unsigned TW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [TW-1:0]    cap_x, eff_x;
  logic [CW-1:0]    cap_eff;
  logic             out_valid_r;
  spq_res_t         out_res_r;
  logic             res_free, start, idle, res_valid;
  spq_res_t         res;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // zero acts as one, anything above the depth as the depth
  assign cap_x = TW'(cap_r);
  assign eff_x = (cap_r == '0) ? TW'(1) :
                 (cap_x > TW'(DEPTH)) ? TW'(DEPTH) : cap_x;
  assign cap_eff = CW'(eff_x);

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign res_free  = !out_valid_r || out_tready;

  spq_ctrl #(
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW),
    .EW       (EW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .cmd            (spq_cmd_t'(in_tdata[1:0])),
    .new_key        (in_tdata[33:2]),
    .new_display_id (in_tdata[49:34]),
    .new_handle     (in_tdata[65:50]),
    .position       (in_tdata[69:66]),
    .search_id      (in_tdata[85:70]),
    .cap_eff        (cap_eff),
    .res_free       (res_free),
    .idle           (idle),
    .res_valid      (res_valid),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  spq_mem #(
    .AW (AW),
    .W  (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r};

endmodule

// File: rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // field positions in out_tdata
  logic [1:0]       res_status;
  logic [CAP_W-1:0] res_occ;
  logic             res_empty;
  logic             res_full;

  assign res_status = out_tdata[1:0];
  assign res_occ    = out_tdata[71:67];
  assign res_empty  = out_tdata[72];
  assign res_full   = out_tdata[73];

  `SPQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SPQ_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result pending after reset")
  `SPQ_ASSERT(a_empty_flag, out_tvalid |-> (res_empty == (res_occ == '0)), "empty flag disagrees with occupancy")
  `SPQ_ASSERT(a_full_refuse, out_tvalid && res_status == ST_FULL |-> res_full, "insert refused while not full")
  `SPQ_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);
